>>> sv/mbft_pkg.sv
// Package for the misaligned bearing film thickness core.
// Holds the transaction types, register indexes, CORDIC constants and the arctangent table.
// No dependencies.
package mbft_pkg;

  localparam int INDEX_BITS_DEF        = 16;
  localparam int SINCOS_ITERATIONS_DEF = 24;

  // Width of the CORDIC datapath (x, y and residual angle).
  localparam int CW = 34;

  // CORDIC start value: the inverse gain 0.607252935 in Q30.
  localparam logic signed [CW-1:0] CORDIC_GAIN_Q30 = CW'(652032874);

  typedef enum logic [2:0] {
    REG_CLEARANCE      = 3'd0,
    REG_ECCENTRICITY   = 3'd1,
    REG_ATTITUDE_ANGLE = 3'd2,
    REG_SLOPE_X        = 3'd3,
    REG_SLOPE_Y        = 3'd4,
    REG_BEARING_LENGTH = 3'd5,
    REG_THETA_STEP     = 3'd6,
    REG_AXIAL_STEP     = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic [15:0] theta_index;
    logic [15:0] axial_index;
  } item_t;

  typedef struct packed {
    logic signed [31:0] thickness;
    logic               saturated;
  } result_t;

  // atan(2^-i) in units of 2^-32 turn.
  function automatic logic [31:0] atan_turn(input int i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

endpackage

>>> sv/mbft_cordic.sv
// Pipelined rotation-mode CORDIC giving cosine and sine in Q30 of an angle in 2^-32 turns.
// Depends on mbft_pkg. Takes one new angle per cycle.
module mbft_cordic #(
  parameter int ITER = mbft_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic                            clk,
  input  logic [31:0]                     angle,
  output logic signed [mbft_pkg::CW-1:0]  cos_q,
  output logic signed [mbft_pkg::CW-1:0]  sin_q
);
  import mbft_pkg::*;

  localparam logic signed [CW-1:0] QUARTER = CW'(64'sd1073741824);
  localparam logic signed [CW-1:0] HALF    = CW'(64'sd2147483648);

  logic signed [CW-1:0] xs   [0:ITER];
  logic signed [CW-1:0] ys   [0:ITER];
  logic signed [CW-1:0] zs   [0:ITER];
  logic                 flip [0:ITER];

  logic signed [CW-1:0] z_in;
  logic signed [CW-1:0] z_fold;
  logic                 flip_in;

  // Fold the angle into the right half plane; for a folded angle both results are negated later.
  always_comb begin
    z_in = CW'($signed(angle));
    if (z_in > QUARTER) begin
      z_fold  = z_in - HALF;
      flip_in = 1'b1;
    end else if (z_in < -QUARTER) begin
      z_fold  = z_in + HALF;
      flip_in = 1'b1;
    end else begin
      z_fold  = z_in;
      flip_in = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    xs[0]   <= CORDIC_GAIN_Q30;
    ys[0]   <= '0;
    zs[0]   <= z_fold;
    flip[0] <= flip_in;
  end

  for (genvar i = 0; i < ITER; i++) begin : g_stage
    localparam logic signed [CW-1:0] ATAN = CW'({1'b0, atan_turn(i)});
    always_ff @(posedge clk) begin
      if (!zs[i][CW-1]) begin
        xs[i+1] <= xs[i] - (ys[i] >>> i);
        ys[i+1] <= ys[i] + (xs[i] >>> i);
        zs[i+1] <= zs[i] - ATAN;
      end else begin
        xs[i+1] <= xs[i] + (ys[i] >>> i);
        ys[i+1] <= ys[i] - (xs[i] >>> i);
        zs[i+1] <= zs[i] + ATAN;
      end
      flip[i+1] <= flip[i];
    end
  end

  always_ff @(posedge clk) begin
    cos_q <= flip[ITER] ? -xs[ITER] : xs[ITER];
    sin_q <= flip[ITER] ? -ys[ITER] : ys[ITER];
  end

endmodule

>>> sv/misaligned_bearing_film_thickness_core.sv
// Top level of the misaligned journal bearing film thickness core.
// Depends on mbft_pkg and mbft_cordic.
// One transaction enters per clock while busy is low and its result leaves from the last stage,
// so the sustained rate is one cell per cycle. The pipeline is made up of the
// three input stages, the two CORDIC pipelines (one stage per iteration plus fold and sign
// stages) and the multiply, tilt, product, sum and subtract stages that follow. The result
// is shown for exactly one cycle on done and cannot be held off, so no transaction ever
// waits inside the block; busy is high during reset and for the first cycle after it.
// Configuration registers are written through cfg_we, cfg_addr and cfg_wdata and must only
// change while no transaction is in flight.
module misaligned_bearing_film_thickness_core #(
  parameter int INDEX_BITS        = mbft_pkg::INDEX_BITS_DEF,
  parameter int SINCOS_ITERATIONS = mbft_pkg::SINCOS_ITERATIONS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  mbft_pkg::item_t     item,
  output logic                busy,
  output logic                done,
  output mbft_pkg::result_t   result,
  input  logic                cfg_we,
  input  mbft_pkg::reg_index_t cfg_addr,
  input  logic [31:0]         cfg_wdata
);
  import mbft_pkg::*;

  // Pipeline bookkeeping: CORDIC latency and total number of valid stages.
  localparam int LAT = SINCOS_ITERATIONS + 2;
  localparam int NV  = LAT + 8;
  // Axial product width and the clamp limits of the doubled axial offset.
  localparam int PAW = INDEX_BITS + 32;
  localparam logic signed [PAW:0] D2_HI = (PAW+1)'(64'sd4294967295);
  localparam logic signed [PAW:0] D2_LO = -D2_HI;
  localparam logic signed [36:0] EX_HI = 37'(64'sd2147483647);
  localparam logic signed [36:0] EX_LO = 37'(-64'sd2147483648);
  localparam logic signed [37:0] H_HI  = 38'(64'sd2147483647);
  localparam logic signed [37:0] H_LO  = 38'(-64'sd2147483648);

  // Configuration registers.
  logic [30:0]        clearance;
  logic [30:0]        eccentricity;
  logic [15:0]        attitude_angle;
  logic signed [31:0] slope_x;
  logic signed [31:0] slope_y;
  logic [30:0]        bearing_length;
  logic [31:0]        theta_step;
  logic [30:0]        axial_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearance      <= '0;
      eccentricity   <= '0;
      attitude_angle <= '0;
      slope_x        <= '0;
      slope_y        <= '0;
      bearing_length <= '0;
      theta_step     <= '0;
      axial_step     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CLEARANCE:      clearance      <= cfg_wdata[30:0];
        REG_ECCENTRICITY:   eccentricity   <= cfg_wdata[30:0];
        REG_ATTITUDE_ANGLE: attitude_angle <= cfg_wdata[15:0];
        REG_SLOPE_X:        slope_x        <= $signed(cfg_wdata);
        REG_SLOPE_Y:        slope_y        <= $signed(cfg_wdata);
        REG_BEARING_LENGTH: bearing_length <= cfg_wdata[30:0];
        REG_THETA_STEP:     theta_step     <= cfg_wdata;
        REG_AXIAL_STEP:     axial_step     <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  // Busy during reset and for the first cycle after it.
  always_ff @(posedge clk) begin
    busy <= rst;
  end

  logic accept;
  assign accept = start && !busy;

  // Valid bits that travel alongside the data; the last one is the result strobe.
  logic [NV-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NV-2:0], accept};
    end
  end
  assign done = vld[NV-1];

  // Stage 1: masked indices.
  logic [INDEX_BITS-1:0] ti_q, ai_q;
  always_ff @(posedge clk) begin
    ti_q <= INDEX_BITS'(item.theta_index);
    ai_q <= INDEX_BITS'(item.axial_index);
  end

  // Stage 2: cell-centre products (2*index+1) * step.
  logic [INDEX_BITS+32:0] pt_q;
  logic [PAW-1:0]         pa_q;
  always_ff @(posedge clk) begin
    pt_q <= (INDEX_BITS+33)'({ti_q, 1'b1}) * (INDEX_BITS+33)'(theta_step);
    pa_q <= PAW'({ai_q, 1'b1}) * PAW'(axial_step);
  end

  // Stage 3: cell angle and clamped doubled axial offset.
  logic [31:0]        theta_q;
  logic signed [32:0] d2_q;
  logic               d2_sat_q;
  logic signed [PAW:0] d2_raw;
  assign d2_raw = $signed({1'b0, pa_q}) - $signed((PAW+1)'(bearing_length));
  always_ff @(posedge clk) begin
    theta_q <= pt_q[32:1];
    if (d2_raw > D2_HI) begin
      d2_q     <= 33'(D2_HI);
      d2_sat_q <= 1'b1;
    end else if (d2_raw < D2_LO) begin
      d2_q     <= 33'(D2_LO);
      d2_sat_q <= 1'b1;
    end else begin
      d2_q     <= 33'(d2_raw);
      d2_sat_q <= 1'b0;
    end
  end

  // Both angles go through their own CORDIC pipeline in lockstep.
  logic signed [CW-1:0] ct, st, cp, sp;

  mbft_cordic #(.ITER(SINCOS_ITERATIONS)) u_cordic_theta (
    .clk   (clk),
    .angle (theta_q),
    .cos_q (ct),
    .sin_q (st)
  );

  mbft_cordic #(.ITER(SINCOS_ITERATIONS)) u_cordic_psi (
    .clk   (clk),
    .angle ({attitude_angle, 16'h0000}),
    .cos_q (cp),
    .sin_q (sp)
  );

  // Tilt terms, formed right after stage 3 and delayed to meet the CORDIC outputs.
  typedef struct packed {
    logic signed [33:0] tx;
    logic signed [33:0] ty;
    logic               sat;
  } side_t;

  side_t side [0:LAT];
  logic signed [64:0] tx_full, ty_full;
  assign tx_full = slope_x * d2_q;
  assign ty_full = slope_y * d2_q;

  always_ff @(posedge clk) begin
    side[0].tx  <= tx_full[64:31];
    side[0].ty  <= ty_full[64:31];
    side[0].sat <= d2_sat_q;
    for (int k = 1; k <= LAT; k++) begin
      side[k] <= side[k-1];
    end
  end

  // Mid-length eccentricity components; cell cos and sin are delayed through ct_d1/st_d1 and ct_d2/st_d2.
  logic signed [65:0]   exc_full, eyc_full;
  logic signed [35:0]   exc_q, eyc_q;
  logic signed [CW-1:0] ct_d1, st_d1, ct_d2, st_d2;
  assign exc_full = $signed({1'b0, eccentricity}) * cp;
  assign eyc_full = $signed({1'b0, eccentricity}) * sp;
  always_ff @(posedge clk) begin
    exc_q <= exc_full[65:30];
    eyc_q <= eyc_full[65:30];
    ct_d1 <= ct;
    st_d1 <= st;
    ct_d2 <= ct_d1;
    st_d2 <= st_d1;
  end

  // Tilted eccentricity, saturated to 32 bits.
  logic signed [36:0] ex_sum, ey_sum;
  logic signed [31:0] ex_q, ey_q;
  logic               ex_sat_q;
  assign ex_sum = 37'(exc_q) + 37'(side[LAT].tx);
  assign ey_sum = 37'(eyc_q) + 37'(side[LAT].ty);
  always_ff @(posedge clk) begin
    ex_q <= (ex_sum > EX_HI) ? 32'(EX_HI) : (ex_sum < EX_LO) ? 32'(EX_LO) : 32'(ex_sum);
    ey_q <= (ey_sum > EX_HI) ? 32'(EX_HI) : (ey_sum < EX_LO) ? 32'(EX_LO) : 32'(ey_sum);
    ex_sat_q <= side[LAT].sat || (ex_sum > EX_HI) || (ex_sum < EX_LO)
                || (ey_sum > EX_HI) || (ey_sum < EX_LO);
  end

  // Projection products.
  logic signed [65:0] px_q, py_q;
  logic               p_sat_q;
  always_ff @(posedge clk) begin
    px_q    <= ex_q * ct_d2;
    py_q    <= ey_q * st_d2;
    p_sat_q <= ex_sat_q;
  end

  // Sum of the projections.
  logic signed [66:0] acc_q;
  logic               a_sat_q;
  always_ff @(posedge clk) begin
    acc_q   <= 67'(px_q) + 67'(py_q);
    a_sat_q <= p_sat_q;
  end

  // Film thickness and final saturation; the scaled sum is sign-extended.
  logic signed [37:0] h_raw;
  assign h_raw = $signed(38'(clearance)) - 38'($signed(acc_q[66:30]));
  always_ff @(posedge clk) begin
    result.thickness <= (h_raw > H_HI) ? 32'(H_HI) :
                        (h_raw < H_LO) ? 32'(H_LO) : 32'(h_raw);
    result.saturated <= a_sat_q || (h_raw > H_HI) || (h_raw < H_LO);
  end

`ifndef SYNTHESIS
  // Every accepted transaction is followed by its result strobe on done.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##(NV) done)
    else $error("result strobe missing after accepted transaction");

  // A result strobe always comes with the last valid bit set and never straight after a reset.
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> vld[NV-1] && !$past(rst))
    else $error("result strobe without transaction");

  // Reset empties the pipeline.
  a_reset_flush: assert property (@(posedge clk)
    rst |=> !done && vld == '0)
    else $error("pipeline not flushed by reset");
`endif

endmodule
